[rtl/rbst_pkg.sv]
// ============================================================================
// rbst_pkg
// Shared types and constants for the ray/box slab test pipeline.
// ============================================================================
package rbst_pkg;

    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ORIGIN_X      = 3'd0,
        REG_ORIGIN_Y      = 3'd1,
        REG_ORIGIN_Z      = 3'd2,
        REG_RECIP_DIR_X   = 3'd3,
        REG_RECIP_DIR_Y   = 3'd4,
        REG_RECIP_DIR_Z   = 3'd5,
        REG_SKIP_VERTICAL = 3'd6
    } cfg_reg_t;

    // travels alongside the data; valid goes through every stage, skip_y up to the y merge
    typedef struct packed {
        logic valid;
        logic skip_y;
    } ctl_t;

endpackage

[rtl/rbst_slab.sv]
// ============================================================================
// rbst_slab
// One axis: bound differences, products with the reciprocal, then ordering
// into near/far parameters. Three register stages.
// ============================================================================
module rbst_slab #(
    parameter int COORD_WIDTH = 24,
    parameter int RECIP_WIDTH = 32,
    localparam int DIFF_W = COORD_WIDTH + 1,
    localparam int PROD_W = COORD_WIDTH + RECIP_WIDTH + 1
) (
    input  logic                          clk,
    input  logic signed [COORD_WIDTH-1:0] bound_min,
    input  logic signed [COORD_WIDTH-1:0] bound_max,
    input  logic signed [COORD_WIDTH-1:0] origin,
    input  logic signed [RECIP_WIDTH-1:0] recip,
    output logic signed [PROD_W-1:0]      lo,
    output logic signed [PROD_W-1:0]      hi
);

    logic signed [DIFF_W-1:0] diff_a_reg;
    logic signed [DIFF_W-1:0] diff_b_reg;
    logic signed [DIFF_W-1:0] diff_a_next;
    logic signed [DIFF_W-1:0] diff_b_next;
    logic signed [PROD_W-1:0] prod_a_reg;
    logic signed [PROD_W-1:0] prod_b_reg;
    logic signed [PROD_W-1:0] prod_a_next;
    logic signed [PROD_W-1:0] prod_b_next;
    logic signed [PROD_W-1:0] lo_reg;
    logic signed [PROD_W-1:0] hi_reg;
    logic signed [PROD_W-1:0] lo_next;
    logic signed [PROD_W-1:0] hi_next;

    always_comb
    begin
        diff_a_next = DIFF_W'(bound_min) - DIFF_W'(origin);
        diff_b_next = DIFF_W'(bound_max) - DIFF_W'(origin);
    end

    // exact signed product, DIFF_W x RECIP_WIDTH
    always_comb
    begin
        prod_a_next = PROD_W'(diff_a_reg) * PROD_W'(recip);
        prod_b_next = PROD_W'(diff_b_reg) * PROD_W'(recip);
    end

    always_comb
    begin
        if (prod_a_reg <= prod_b_reg)
        begin
            lo_next = prod_a_reg;
            hi_next = prod_b_reg;
        end
        else
        begin
            lo_next = prod_b_reg;
            hi_next = prod_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_a_reg <= diff_a_next;
        diff_b_reg <= diff_b_next;
        prod_a_reg <= prod_a_next;
        prod_b_reg <= prod_b_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
    end

    assign lo = lo_reg;
    assign hi = hi_reg;

endmodule

[rtl/rbst_merge.sv]
// ============================================================================
// rbst_merge
// Combines the per-axis intervals and makes the hit decision.
// Three register stages.
// ============================================================================
module rbst_merge #(
    parameter int PROD_W = 57
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  rbst_pkg::ctl_t           ctl_in,
    input  logic signed [PROD_W-1:0] lo_x,
    input  logic signed [PROD_W-1:0] hi_x,
    input  logic signed [PROD_W-1:0] lo_y,
    input  logic signed [PROD_W-1:0] hi_y,
    input  logic signed [PROD_W-1:0] lo_z,
    input  logic signed [PROD_W-1:0] hi_z,
    output logic                     done,
    output logic                     hit
);

    rbst_pkg::ctl_t           ctl4_reg;
    logic                     valid5_reg;
    logic                     done_reg;
    logic signed [PROD_W-1:0] enter_xz_reg;
    logic signed [PROD_W-1:0] leave_xz_reg;
    logic signed [PROD_W-1:0] lo_y_reg;
    logic signed [PROD_W-1:0] hi_y_reg;
    logic signed [PROD_W-1:0] enter_reg;
    logic signed [PROD_W-1:0] leave_reg;
    logic                     hit_reg;
    logic signed [PROD_W-1:0] enter_xz_next;
    logic signed [PROD_W-1:0] leave_xz_next;
    logic signed [PROD_W-1:0] enter_next;
    logic signed [PROD_W-1:0] leave_next;
    logic                     hit_next;

    always_comb
    begin
        enter_xz_next = (lo_x >= lo_z) ? lo_x : lo_z;
        leave_xz_next = (hi_x <= hi_z) ? hi_x : hi_z;
    end

    always_comb
    begin
        enter_next = enter_xz_reg;
        leave_next = leave_xz_reg;
        if (!ctl4_reg.skip_y)
        begin
            if (lo_y_reg > enter_xz_reg)
            begin
                enter_next = lo_y_reg;
            end
            if (hi_y_reg < leave_xz_reg)
            begin
                leave_next = hi_y_reg;
            end
        end
    end

    // max(enter, 0) <= leave
    assign hit_next = (enter_reg <= leave_reg) && !leave_reg[PROD_W-1];

    always_ff @(posedge clk)
    begin
        enter_xz_reg <= enter_xz_next;
        leave_xz_reg <= leave_xz_next;
        lo_y_reg     <= lo_y;
        hi_y_reg     <= hi_y;
        enter_reg    <= enter_next;
        leave_reg    <= leave_next;
        hit_reg      <= hit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl4_reg   <= '0;
            valid5_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            ctl4_reg   <= ctl_in;
            valid5_reg <= ctl4_reg.valid;
            done_reg   <= valid5_reg;
        end
    end

    assign done = done_reg;
    assign hit  = hit_reg;

endmodule

[rtl/ray_box_slab_test_top.sv]
// ============================================================================
// ray_box_slab_test_top
// Slab test of a stream of axis-aligned boxes against one configured ray.
// ============================================================================
// Load the ray through the config port while the pipeline is empty, then
// issue one box per cycle with start; busy never rises. Each box returns its
// hit flag with a one-cycle done strobe, in issue order, after it has passed
// through the stages below. The six stages are: bound differences, the
// 25x32 signed products (one multiplier per bound), per-axis ordering, the
// x/z merge, the y merge, and the final compare. Results cannot be held off,
// so the receiver must take every done strobe.
module ray_box_slab_test_top #(
    parameter int COORD_WIDTH = 24,
    parameter int RECIP_WIDTH = 32,
    localparam int CFG_WIDTH = (COORD_WIDTH > RECIP_WIDTH) ? COORD_WIDTH : RECIP_WIDTH,
    localparam int PROD_W = COORD_WIDTH + RECIP_WIDTH + 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [rbst_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_WIDTH-1:0]               cfg_wdata,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [COORD_WIDTH-1:0]      box_min_x,
    input  logic signed [COORD_WIDTH-1:0]      box_min_y,
    input  logic signed [COORD_WIDTH-1:0]      box_min_z,
    input  logic signed [COORD_WIDTH-1:0]      box_max_x,
    input  logic signed [COORD_WIDTH-1:0]      box_max_y,
    input  logic signed [COORD_WIDTH-1:0]      box_max_z,
    output logic                               done,
    output logic                               hit
);

    logic signed [COORD_WIDTH-1:0] origin_x_reg;
    logic signed [COORD_WIDTH-1:0] origin_y_reg;
    logic signed [COORD_WIDTH-1:0] origin_z_reg;
    logic signed [RECIP_WIDTH-1:0] recip_x_reg;
    logic signed [RECIP_WIDTH-1:0] recip_y_reg;
    logic signed [RECIP_WIDTH-1:0] recip_z_reg;
    logic                          skip_reg;

    rbst_pkg::ctl_t ctl0;
    rbst_pkg::ctl_t ctl1_reg;
    rbst_pkg::ctl_t ctl2_reg;
    rbst_pkg::ctl_t ctl3_reg;

    logic signed [PROD_W-1:0] lo_x;
    logic signed [PROD_W-1:0] hi_x;
    logic signed [PROD_W-1:0] lo_y;
    logic signed [PROD_W-1:0] hi_y;
    logic signed [PROD_W-1:0] lo_z;
    logic signed [PROD_W-1:0] hi_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            recip_x_reg  <= '0;
            recip_y_reg  <= '0;
            recip_z_reg  <= '0;
            skip_reg     <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (rbst_pkg::cfg_reg_t'(cfg_index))
                rbst_pkg::REG_ORIGIN_X:      origin_x_reg <= cfg_wdata[COORD_WIDTH-1:0];
                rbst_pkg::REG_ORIGIN_Y:      origin_y_reg <= cfg_wdata[COORD_WIDTH-1:0];
                rbst_pkg::REG_ORIGIN_Z:      origin_z_reg <= cfg_wdata[COORD_WIDTH-1:0];
                rbst_pkg::REG_RECIP_DIR_X:   recip_x_reg  <= cfg_wdata[RECIP_WIDTH-1:0];
                rbst_pkg::REG_RECIP_DIR_Y:   recip_y_reg  <= cfg_wdata[RECIP_WIDTH-1:0];
                rbst_pkg::REG_RECIP_DIR_Z:   recip_z_reg  <= cfg_wdata[RECIP_WIDTH-1:0];
                rbst_pkg::REG_SKIP_VERTICAL: skip_reg     <= cfg_wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    assign busy = 1'b0;

    always_comb
    begin
        ctl0.valid  = start && !busy;
        ctl0.skip_y = skip_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl0;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    rbst_slab #(
        .COORD_WIDTH (COORD_WIDTH),
        .RECIP_WIDTH (RECIP_WIDTH)
    ) u_slab_x (
        .clk       (clk),
        .bound_min (box_min_x),
        .bound_max (box_max_x),
        .origin    (origin_x_reg),
        .recip     (recip_x_reg),
        .lo        (lo_x),
        .hi        (hi_x)
    );

    rbst_slab #(
        .COORD_WIDTH (COORD_WIDTH),
        .RECIP_WIDTH (RECIP_WIDTH)
    ) u_slab_y (
        .clk       (clk),
        .bound_min (box_min_y),
        .bound_max (box_max_y),
        .origin    (origin_y_reg),
        .recip     (recip_y_reg),
        .lo        (lo_y),
        .hi        (hi_y)
    );

    rbst_slab #(
        .COORD_WIDTH (COORD_WIDTH),
        .RECIP_WIDTH (RECIP_WIDTH)
    ) u_slab_z (
        .clk       (clk),
        .bound_min (box_min_z),
        .bound_max (box_max_z),
        .origin    (origin_z_reg),
        .recip     (recip_z_reg),
        .lo        (lo_z),
        .hi        (hi_z)
    );

    rbst_merge #(
        .PROD_W (PROD_W)
    ) u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl_in (ctl3_reg),
        .lo_x   (lo_x),
        .hi_x   (hi_x),
        .lo_y   (lo_y),
        .hi_y   (hi_y),
        .lo_z   (lo_z),
        .hi_z   (hi_z),
        .done   (done),
        .hit    (hit)
    );

endmodule
